### hw/rtl/assert_macros.svh
// Assertion macros used by the RTL (included by text_console_char_writer.sv).
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every clock edge, held off while reset is asserted.
`define ASSERT_CLK(name, prop) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("assertion failed");

// Checked on every clock edge, reset included.
`define ASSERT_ALWAYS(name, prop) \
  name: assert property (@(posedge clk_i) prop) \
    else $error("assertion failed");

`endif

### hw/rtl/tcw_pkg.sv
// Types and constants of the text console character writer.
package tcw_pkg;

  localparam int COLS_DEF = 80;
  localparam int ROWS_DEF = 25;

  localparam logic [15:0] BLANK_CELL = 16'h0F20;

  localparam logic [7:0] CH_BS       = 8'h08;
  localparam logic [7:0] CH_TAB      = 8'h09;
  localparam logic [7:0] CH_LF       = 8'h0A;
  localparam logic [7:0] CH_CR       = 8'h0D;
  localparam logic [7:0] CH_PRINT_LO = 8'h20;
  localparam logic [7:0] CH_PRINT_HI = 8'h7F;

  typedef enum logic [1:0] {
    OP_PUT   = 2'd0,
    OP_CLEAR = 2'd1,
    OP_READ  = 2'd2
  } op_e;

  typedef enum logic [2:0] {
    S_FILL,
    S_IDLE,
    S_READ,
    S_COPY,
    S_FINISH
  } state_e;

endpackage

### hw/rtl/tcw_ram.sv
// Generic simple dual-port RAM, one write port, one registered read port.
module tcw_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2000
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### hw/rtl/text_console_char_writer.sv
// Text console character writer: a COLS x ROWS screen of 16-bit cells held in one RAM.
//
// One transaction on the input channel carries one operation and yields exactly one
// result transaction. A printable character is written to its cell in the accept cycle;
// a cursor-moving control byte writes no cell. Either result is then loaded from the
// finish state. A cell read passes through the read state, which takes the registered
// RAM data, and then the finish state. A clear screen goes through the fill state,
// one blank cell written per cycle, then the finish state. A character that moves the
// cursor past the last row scrolls the screen: rows 1..ROWS-1 are copied up one row,
// then the bottom row is blanked, then the result is loaded from the finish state.
// The single RAM write port limits these sweeps to one cell per cycle. After reset the
// block blanks the whole screen and holds in_stall_o high until that pass is done. The
// input is stalled while an operation is in progress; a finished result waits in the
// output register, so the next operation can be accepted while the result is still
// stalled downstream.
`include "assert_macros.svh"

module text_console_char_writer #(
  parameter int COLS = tcw_pkg::COLS_DEF,
  parameter int ROWS = tcw_pkg::ROWS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // input channel
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  opcode_i,
  input  logic [7:0]  char_code_i,
  input  logic [3:0]  bg_color_i,
  input  logic [3:0]  fg_color_i,
  input  logic [10:0] cell_index_i,
  // result channel
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [10:0] cursor_pos_o,
  output logic        scrolled_o,
  output logic [15:0] read_data_o
);

  import tcw_pkg::*;

  localparam int CELLS  = COLS * ROWS;
  localparam int COPY_N = (ROWS - 1) * COLS;  // cells moved up on a scroll
  localparam int AW     = $clog2(CELLS);
  localparam int CW     = $clog2(COLS);
  localparam int RW     = $clog2(ROWS);

  state_e        state_q, state_d;
  logic [AW-1:0] cnt_q, cnt_d;       // sweep position for fill and copy
  logic [CW-1:0] col_q, col_d;
  logic [RW-1:0] row_q, row_d;
  logic          pend_q, pend_d;     // a result is owed when the sweep ends
  logic          res_scrolled_q, res_scrolled_d;
  logic [15:0]   res_data_q, res_data_d;
  logic          rd_hit_q, rd_hit_d; // read address was in range

  logic          out_valid_q, out_valid_d;
  logic [10:0]   out_pos_q, out_pos_d;
  logic          out_scrolled_q, out_scrolled_d;
  logic [15:0]   out_data_q, out_data_d;

  // RAM ports
  logic          ram_we;
  logic [AW-1:0] ram_waddr, ram_raddr;
  logic [15:0]   ram_wdata, ram_rdata;

  logic          in_acc;
  logic [AW-1:0] cur_lin;            // linear cursor address
  logic [CW:0]   col_n;              // one extra bit for the transient overflow
  logic [RW:0]   row_n;
  logic          out_free;

  tcw_ram #(
    .WIDTH (16),
    .DEPTH (CELLS)
  ) u_screen (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign in_stall_o = (state_q != S_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign cur_lin    = AW'(row_q) * AW'(COLS) + AW'(col_q);
  assign out_free   = !out_valid_q || !out_stall_i;

  // Copy reads run COLS cells ahead of the writes; a read cell command is
  // issued straight from the input fields.
  assign ram_raddr = (state_q == S_COPY) ? cnt_q + AW'(COLS) : AW'(cell_index_i);

  always_comb begin
    state_d        = state_q;
    cnt_d          = cnt_q;
    col_d          = col_q;
    row_d          = row_q;
    pend_d         = pend_q;
    res_scrolled_d = res_scrolled_q;
    res_data_d     = res_data_q;
    rd_hit_d       = rd_hit_q;
    out_valid_d    = out_valid_q && out_stall_i;
    out_pos_d      = out_pos_q;
    out_scrolled_d = out_scrolled_q;
    out_data_d     = out_data_q;
    ram_we         = 1'b0;
    ram_waddr      = cnt_q;
    ram_wdata      = BLANK_CELL;
    col_n          = {1'b0, col_q};
    row_n          = {1'b0, row_q};

    case (state_q)
      S_FILL: begin
        ram_we    = 1'b1;
        ram_waddr = cnt_q;
        ram_wdata = BLANK_CELL;
        if (cnt_q == AW'(CELLS - 1)) begin
          cnt_d   = '0;
          state_d = pend_q ? S_FINISH : S_IDLE;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end

      S_IDLE: begin
        if (in_acc) begin
          res_scrolled_d = 1'b0;
          res_data_d     = '0;
          pend_d         = 1'b1;
          state_d        = S_FINISH;
          case (op_e'(opcode_i))
            OP_PUT: begin
              if (char_code_i == CH_BS) begin
                if (col_q != '0) begin
                  col_n = {1'b0, col_q} - 1'b1;
                end
              end else if (char_code_i == CH_TAB) begin
                col_n = ({1'b0, col_q} + (CW+1)'(8)) & ~(CW+1)'(7);
              end else if (char_code_i == CH_CR) begin
                col_n = '0;
              end else if (char_code_i == CH_LF) begin
                col_n = '0;
                row_n = {1'b0, row_q} + 1'b1;
              end else if (char_code_i inside {[CH_PRINT_LO:CH_PRINT_HI]}) begin
                ram_we    = 1'b1;
                ram_waddr = cur_lin;
                ram_wdata = {bg_color_i, fg_color_i, char_code_i};
                col_n     = {1'b0, col_q} + 1'b1;
              end
              // line wrap
              if (col_n >= (CW+1)'(COLS)) begin
                col_n = '0;
                row_n = row_n + 1'b1;
              end
              col_d = col_n[CW-1:0];
              if (row_n >= (RW+1)'(ROWS)) begin
                // past the last row: scroll up one row
                row_d          = RW'(ROWS - 1);
                res_scrolled_d = 1'b1;
                cnt_d          = '0;
                state_d        = S_COPY;
              end else begin
                row_d = row_n[RW-1:0];
              end
            end
            OP_CLEAR: begin
              col_d   = '0;
              row_d   = '0;
              cnt_d   = '0;
              state_d = S_FILL;
            end
            OP_READ: begin
              rd_hit_d = (32'(cell_index_i) < 32'(CELLS));
              state_d  = S_READ;
            end
            default: begin
              // unused opcode: no change
            end
          endcase
        end
      end

      S_READ: begin
        res_data_d = rd_hit_q ? ram_rdata : '0;
        state_d    = S_FINISH;
      end

      S_COPY: begin
        // write back the cell read in the previous cycle, one row up
        if (cnt_q != '0) begin
          ram_we    = 1'b1;
          ram_waddr = cnt_q - 1'b1;
          ram_wdata = ram_rdata;
        end
        if (cnt_q == AW'(COPY_N)) begin
          state_d = S_FILL;  // blank the bottom row from here
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end

      S_FINISH: begin
        if (out_free) begin
          out_valid_d    = 1'b1;
          out_pos_d      = 11'(cur_lin);
          out_scrolled_d = res_scrolled_q;
          out_data_d     = res_data_q;
          pend_d         = 1'b0;
          state_d        = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_FILL;
      cnt_q       <= '0;
      col_q       <= '0;
      row_q       <= '0;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      col_q       <= col_d;
      row_q       <= row_d;
      pend_q      <= pend_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_scrolled_q <= res_scrolled_d;
    res_data_q     <= res_data_d;
    rd_hit_q       <= rd_hit_d;
    out_pos_q      <= out_pos_d;
    out_scrolled_q <= out_scrolled_d;
    out_data_q     <= out_data_d;
  end

  assign out_valid_o  = out_valid_q;
  assign cursor_pos_o = out_pos_q;
  assign scrolled_o   = out_scrolled_q;
  assign read_data_o  = out_data_q;

  // a scrolling result always leaves the cursor on the bottom row
  `ASSERT_CLK(a_scroll_row, (state_q == S_FINISH && res_scrolled_q) |-> (row_q == RW'(ROWS - 1)))
  // cursor never rests outside the screen
  `ASSERT_CLK(a_cursor_range, (32'(col_q) < 32'(COLS)) && (32'(row_q) < 32'(ROWS)))
  // a new result is only loaded from the finish step
  `ASSERT_CLK(a_out_load, $rose(out_valid_o) |-> ($past(state_q) == S_FINISH))
  // the screen RAM is not written while a cell read is in flight
  `ASSERT_CLK(a_read_no_write, (state_q == S_READ) |-> !ram_we)

endmodule
